// File: rtl/rmms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmms_pkg
// Shared types and constants of the rate-monotonic multicore scheduler.
// ----------------------------------------------------------------------------
package rmms_pkg;

  localparam int NUM_TASKS = 16;
  localparam int NUM_CORES = 8;
  localparam int TIME_W    = 16;
  localparam int SLOT_W    = $clog2(NUM_TASKS);
  localparam int CORE_W    = $clog2(NUM_CORES);
  localparam int NT_W      = $clog2(NUM_TASKS + 1);
  localparam int NC_W      = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CORES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TASKS = 1'b1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    STAT_READY,
    STAT_RUN,
    STAT_DONE
  } status_e;

  typedef struct packed {
    logic                 load;
    logic [SLOT_W-1:0]    load_slot;
    logic [TIME_W-1:0]    arrival;
    logic [TIME_W-1:0]    burst;
    logic [TIME_W-1:0]    period;
    logic [NUM_TASKS-1:0] ready_mask;
    logic                 run_en;
    logic [SLOT_W-1:0]    run_slot;
    logic                 fin_en;
    logic                 dec_en;
    logic [SLOT_W-1:0]    upd_slot;
    logic [SLOT_W-1:0]    rd_addr;
  } tbl_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]    rd_arrival;
    logic [TIME_W-1:0]    rd_period;
    logic [TIME_W-1:0]    rd_remaining;
    logic [TIME_W-1:0]    rd_start;
    status_e              rd_status;
    logic [NUM_TASKS-1:0] done_mask;
  } tbl_rsp_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    sat_inc = (&v) ? v : v + TIME_W'(1);
  endfunction

endpackage

// File: rtl/rmms_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmms_table
// Task table: arrival, period, remaining, start tick and status per slot,
// one read address per cycle.
// ----------------------------------------------------------------------------
module rmms_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [rmms_pkg::TIME_W-1:0] now_i,
  input  rmms_pkg::tbl_cmd_t      cmd_i,
  output rmms_pkg::tbl_rsp_t      rsp_o
);

  logic [rmms_pkg::TIME_W-1:0] arrival_q [rmms_pkg::NUM_TASKS];
  logic [rmms_pkg::TIME_W-1:0] period_q  [rmms_pkg::NUM_TASKS];
  logic [rmms_pkg::TIME_W-1:0] remain_q  [rmms_pkg::NUM_TASKS];
  logic [rmms_pkg::TIME_W-1:0] start_q   [rmms_pkg::NUM_TASKS];
  rmms_pkg::status_e           status_q  [rmms_pkg::NUM_TASKS];
  logic [rmms_pkg::NUM_TASKS-1:0] started_q;

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < rmms_pkg::NUM_TASKS; t++) begin
      if (cmd_i.run_en && cmd_i.run_slot == rmms_pkg::SLOT_W'(t) && !started_q[t]) begin
        start_q[t] <= now_i;
      end
      if (cmd_i.fin_en && cmd_i.upd_slot == rmms_pkg::SLOT_W'(t)) begin
        remain_q[t] <= '0;
      end else if (cmd_i.dec_en && cmd_i.upd_slot == rmms_pkg::SLOT_W'(t)) begin
        remain_q[t] <= remain_q[t] - rmms_pkg::TIME_W'(1);
      end
      if (cmd_i.load && cmd_i.load_slot == rmms_pkg::SLOT_W'(t)) begin
        arrival_q[t] <= cmd_i.arrival;
        remain_q[t]  <= cmd_i.burst;
        period_q[t]  <= cmd_i.period;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < rmms_pkg::NUM_TASKS; t++) begin
        status_q[t] <= rmms_pkg::STAT_READY;
      end
      started_q <= '0;
    end else begin
      for (int t = 0; t < rmms_pkg::NUM_TASKS; t++) begin
        if (cmd_i.ready_mask[t]) begin
          status_q[t] <= rmms_pkg::STAT_READY;
        end
        if (cmd_i.run_en && cmd_i.run_slot == rmms_pkg::SLOT_W'(t)) begin
          status_q[t]  <= rmms_pkg::STAT_RUN;
          started_q[t] <= 1'b1;
        end
        if (cmd_i.fin_en && cmd_i.upd_slot == rmms_pkg::SLOT_W'(t)) begin
          status_q[t] <= rmms_pkg::STAT_DONE;
        end
        if (cmd_i.load && cmd_i.load_slot == rmms_pkg::SLOT_W'(t)) begin
          status_q[t]  <= rmms_pkg::STAT_READY;
          started_q[t] <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    rsp_o.rd_arrival   = arrival_q[cmd_i.rd_addr];
    rsp_o.rd_period    = period_q[cmd_i.rd_addr];
    rsp_o.rd_remaining = remain_q[cmd_i.rd_addr];
    rsp_o.rd_start     = start_q[cmd_i.rd_addr];
    rsp_o.rd_status    = status_q[cmd_i.rd_addr];
    for (int t = 0; t < rmms_pkg::NUM_TASKS; t++) begin
      rsp_o.done_mask[t] = (status_q[t] == rmms_pkg::STAT_DONE);
    end
  end

endmodule

// File: rtl/rate_monotonic_multicore_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_multicore_scheduler_top
// Global preemptive rate-monotonic scheduler over a 16-entry task table.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. mode_i = 0 loads
//   one task entry. mode_i = 1 runs one scheduling tick.
//   A tick walks the table under a small sequencer with one compare unit:
//   one pass over the active tasks to collect arrived ready tasks, then per
//   candidate one table scan, a core scan and a place step, then a fill pass
//   with one table scan per idle core, an execute pass and a result pass
//   over the active cores. With no active core a tick only advances the
//   tick counter and busy stays low; otherwise busy stays high for the
//   whole tick.
//   Results: valid_o marks one result per active core, in core order, on
//   consecutive cycles; last_of_tick_o flags the final one. The receiver
//   cannot stall.
//   Config: cfg_we_i writes active_cores (index 0) or active_tasks
//   (index 1), only while busy is low.
//   Reset: all tasks ready and not started, all cores idle, tick 0,
//   4 cores and 16 tasks active.
// ----------------------------------------------------------------------------
module rate_monotonic_multicore_scheduler_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode_i,
  input  logic [3:0]                       task_slot_i,
  input  logic [15:0]                      arrival_tick_i,
  input  logic [15:0]                      burst_length_i,
  input  logic [15:0]                      period_length_i,
  input  logic                             cfg_we_i,
  input  logic [rmms_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rmms_pkg::CFG_W-1:0]       cfg_data_i,
  output logic                             valid_o,
  output logic [15:0]                      tick_number_o,
  output logic [2:0]                       core_number_o,
  output logic                             core_busy_o,
  output logic [3:0]                       running_slot_o,
  output logic                             finished_now_o,
  output logic [15:0]                      first_start_tick_o,
  output logic [15:0]                      finish_tick_o,
  output logic                             all_finished_o,
  output logic                             last_of_tick_o
);

  localparam int TW = rmms_pkg::TIME_W;
  localparam int SW = rmms_pkg::SLOT_W;
  localparam int CW = rmms_pkg::CORE_W;
  localparam int NC = rmms_pkg::NUM_CORES;
  localparam int NT = rmms_pkg::NUM_TASKS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_QBLD   = 4'd1;
  localparam logic [3:0] ST_ASCAN  = 4'd2;
  localparam logic [3:0] ST_ACORE  = 4'd3;
  localparam logic [3:0] ST_APLACE = 4'd4;
  localparam logic [3:0] ST_BCORE  = 4'd5;
  localparam logic [3:0] ST_BSCAN  = 4'd6;
  localparam logic [3:0] ST_EXEC   = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] t_q, t_d;
  logic [CW-1:0] c_q, c_d;
  logic [NT-1:0] q_q, q_d;
  logic          bf_q, bf_d;
  logic [SW-1:0] bs_q, bs_d;
  logic [TW-1:0] bp_q, bp_d;
  logic          wf_q, wf_d;
  logic [TW-1:0] worst_q, worst_d;
  logic [CW-1:0] target_q, target_d;
  logic          idle_q, idle_d;
  logic [NC-1:0] cv_q, cv_d;
  logic [SW-1:0] cs_q [NC];
  logic [SW-1:0] cs_d [NC];
  logic [TW-1:0] cp_q [NC];
  logic [TW-1:0] cp_d [NC];
  logic [NC-1:0] rbusy_q, rbusy_d;
  logic [NC-1:0] rfin_q, rfin_d;
  logic [SW-1:0] rslot_q [NC];
  logic [SW-1:0] rslot_d [NC];
  logic [TW-1:0] rstart_q [NC];
  logic [TW-1:0] rstart_d [NC];
  logic [TW-1:0] rftick_q [NC];
  logic [TW-1:0] rftick_d [NC];
  logic [TW-1:0] tick_q, tick_d;
  logic [rmms_pkg::NC_W-1:0] nc_q, nc_d;
  logic [rmms_pkg::NT_W-1:0] nt_q, nt_d;

  rmms_pkg::tbl_cmd_t cmd;
  rmms_pkg::tbl_rsp_t rsp;

  logic          t_last, c_last, elig, take, bf_n;
  logic [SW-1:0] bs_n;
  logic [TW-1:0] bp_n;
  logic [NT-1:0] act_mask;

  rmms_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .now_i  (tick_q),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  assign busy   = (state_q != ST_IDLE);
  assign t_last = ({1'b0, t_q} + rmms_pkg::NT_W'(1)) == nt_q;
  assign c_last = ({1'b0, c_q} + rmms_pkg::NC_W'(1)) == nc_q;

  // shared min-period compare
  always_comb begin
    if (state_q == ST_ASCAN) begin
      elig = q_q[t_q];
    end else begin
      elig = (rsp.rd_status == rmms_pkg::STAT_READY) && (rsp.rd_arrival <= tick_q);
    end
    take = elig && (!bf_q || rsp.rd_period < bp_q);
    bf_n = bf_q | take;
    bs_n = take ? t_q : bs_q;
    bp_n = take ? rsp.rd_period : bp_q;
  end

  always_comb begin
    logic [rmms_pkg::NC_W-1:0] ncv;
    logic [rmms_pkg::NT_W-1:0] ntv;
    state_d  = state_q;
    t_d      = t_q;
    c_d      = c_q;
    q_d      = q_q;
    bf_d     = bf_q;
    bs_d     = bs_q;
    bp_d     = bp_q;
    wf_d     = wf_q;
    worst_d  = worst_q;
    target_d = target_q;
    idle_d   = idle_q;
    cv_d     = cv_q;
    cs_d     = cs_q;
    cp_d     = cp_q;
    rbusy_d  = rbusy_q;
    rfin_d   = rfin_q;
    rslot_d  = rslot_q;
    rstart_d = rstart_q;
    rftick_d = rftick_q;
    tick_d   = tick_q;
    nc_d     = nc_q;
    nt_d     = nt_q;
    ncv      = '0;
    ntv      = '0;
    cmd         = '0;
    cmd.rd_addr = t_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          if (cfg_idx_i == rmms_pkg::CFG_ACTIVE_CORES) begin
            ncv = (cfg_data_i[3:0] > rmms_pkg::NC_W'(NC)) ? rmms_pkg::NC_W'(NC)
                                                           : cfg_data_i[3:0];
            nc_d = ncv;
            for (int c = 0; c < NC; c++) begin
              if (cv_q[c] && rmms_pkg::NC_W'(c) >= ncv) begin
                cmd.ready_mask[cs_q[c]] = 1'b1;
                cv_d[c] = 1'b0;
                cs_d[c] = '0;
              end
            end
          end else begin
            ntv = (cfg_data_i > rmms_pkg::NT_W'(NT)) ? rmms_pkg::NT_W'(NT) : cfg_data_i;
            nt_d = ntv;
            for (int c = 0; c < NC; c++) begin
              if (cv_q[c] && {1'b0, cs_q[c]} >= ntv) begin
                cmd.ready_mask[cs_q[c]] = 1'b1;
                cv_d[c] = 1'b0;
                cs_d[c] = '0;
              end
            end
          end
        end
        if (start) begin
          if (mode_i == rmms_pkg::MODE_LOAD) begin
            cmd.load      = 1'b1;
            cmd.load_slot = task_slot_i;
            cmd.arrival   = arrival_tick_i;
            cmd.burst     = burst_length_i;
            cmd.period    = period_length_i;
            for (int c = 0; c < NC; c++) begin
              if (cv_q[c] && cs_q[c] == task_slot_i) begin
                cv_d[c] = 1'b0;
                cs_d[c] = '0;
              end
            end
          end else if (nc_q == '0) begin
            tick_d = rmms_pkg::sat_inc(tick_q);
          end else if (nt_q == '0) begin
            state_d = ST_EXEC;
            c_d     = '0;
          end else begin
            state_d = ST_QBLD;
            t_d     = '0;
            q_d     = '0;
          end
        end
      end
      ST_QBLD: begin
        q_d[t_q] = (rsp.rd_status == rmms_pkg::STAT_READY) && (rsp.rd_arrival <= tick_q);
        if (t_last) begin
          state_d = ST_ASCAN;
          t_d     = '0;
          bf_d    = 1'b0;
        end else begin
          t_d = t_q + SW'(1);
        end
      end
      ST_ASCAN: begin
        bf_d = bf_n;
        bs_d = bs_n;
        bp_d = bp_n;
        if (t_last) begin
          t_d = '0;
          c_d = '0;
          if (bf_n) begin
            q_d[bs_n] = 1'b0;
            state_d   = ST_ACORE;
            wf_d      = 1'b0;
            idle_d    = 1'b0;
          end else begin
            state_d = ST_BCORE;
          end
        end else begin
          t_d = t_q + SW'(1);
        end
      end
      ST_ACORE: begin
        if (!cv_q[c_q]) begin
          target_d = c_q;
          idle_d   = 1'b1;
          state_d  = ST_APLACE;
        end else begin
          if (!wf_q || cp_q[c_q] > worst_q) begin
            wf_d     = 1'b1;
            worst_d  = cp_q[c_q];
            target_d = c_q;
          end
          if (c_last) begin
            state_d = ST_APLACE;
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      ST_APLACE: begin
        if (idle_q || bp_q < worst_q) begin
          if (!idle_q) begin
            cmd.ready_mask[cs_q[target_q]] = 1'b1;
          end
          cv_d[target_q] = 1'b1;
          cs_d[target_q] = bs_q;
          cp_d[target_q] = bp_q;
          cmd.run_en     = 1'b1;
          cmd.run_slot   = bs_q;
          state_d        = ST_ASCAN;
          t_d            = '0;
          bf_d           = 1'b0;
        end else begin
          // later candidates cannot win either
          state_d = ST_BCORE;
          c_d     = '0;
        end
      end
      ST_BCORE: begin
        if (!cv_q[c_q]) begin
          state_d = ST_BSCAN;
          t_d     = '0;
          bf_d    = 1'b0;
        end else if (c_last) begin
          state_d = ST_EXEC;
          c_d     = '0;
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      ST_BSCAN: begin
        bf_d = bf_n;
        bs_d = bs_n;
        bp_d = bp_n;
        if (t_last) begin
          if (bf_n) begin
            cv_d[c_q]    = 1'b1;
            cs_d[c_q]    = bs_n;
            cp_d[c_q]    = bp_n;
            cmd.run_en   = 1'b1;
            cmd.run_slot = bs_n;
          end
          if (c_last) begin
            state_d = ST_EXEC;
            c_d     = '0;
          end else begin
            state_d = ST_BCORE;
            c_d     = c_q + CW'(1);
          end
        end else begin
          t_d = t_q + SW'(1);
        end
      end
      ST_EXEC: begin
        cmd.rd_addr    = cs_q[c_q];
        cmd.upd_slot   = cs_q[c_q];
        rbusy_d[c_q]   = cv_q[c_q];
        rfin_d[c_q]    = 1'b0;
        rslot_d[c_q]   = '0;
        rstart_d[c_q]  = '0;
        rftick_d[c_q]  = '0;
        if (cv_q[c_q]) begin
          rslot_d[c_q]  = cs_q[c_q];
          rstart_d[c_q] = rsp.rd_start;
          if (rsp.rd_remaining <= TW'(1)) begin
            cmd.fin_en    = 1'b1;
            cv_d[c_q]     = 1'b0;
            cs_d[c_q]     = '0;
            rfin_d[c_q]   = 1'b1;
            rftick_d[c_q] = rmms_pkg::sat_inc(tick_q);
          end else begin
            cmd.dec_en = 1'b1;
          end
        end
        if (c_last) begin
          state_d = ST_EMIT;
          c_d     = '0;
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      ST_EMIT: begin
        if (c_last) begin
          state_d = ST_IDLE;
          tick_d  = rmms_pkg::sat_inc(tick_q);
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      c_q     <= '0;
      q_q     <= '0;
      bf_q    <= 1'b0;
      wf_q    <= 1'b0;
      idle_q  <= 1'b0;
      cv_q    <= '0;
      for (int c = 0; c < NC; c++) begin
        cs_q[c] <= '0;
      end
      tick_q  <= '0;
      nc_q    <= rmms_pkg::NC_W'(4);
      nt_q    <= rmms_pkg::NT_W'(NT);
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      c_q     <= c_d;
      q_q     <= q_d;
      bf_q    <= bf_d;
      wf_q    <= wf_d;
      idle_q  <= idle_d;
      cv_q    <= cv_d;
      cs_q    <= cs_d;
      tick_q  <= tick_d;
      nc_q    <= nc_d;
      nt_q    <= nt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bs_q     <= bs_d;
    bp_q     <= bp_d;
    worst_q  <= worst_d;
    target_q <= target_d;
    cp_q     <= cp_d;
    rbusy_q  <= rbusy_d;
    rfin_q   <= rfin_d;
    rslot_q  <= rslot_d;
    rstart_q <= rstart_d;
    rftick_q <= rftick_d;
  end

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      act_mask[t] = rmms_pkg::NT_W'(t) < nt_q;
    end
  end

  assign valid_o            = (state_q == ST_EMIT);
  assign tick_number_o      = tick_q;
  assign core_number_o      = c_q;
  assign core_busy_o        = rbusy_q[c_q];
  assign running_slot_o     = rslot_q[c_q];
  assign finished_now_o     = rfin_q[c_q];
  assign first_start_tick_o = rstart_q[c_q];
  assign finish_tick_o      = rftick_q[c_q];
  assign all_finished_o     = &(rsp.done_mask | ~act_mask);
  assign last_of_tick_o     = c_last;

  a_tick_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_of_tick_o |=> !busy)
    else $error("tick did not end after last result");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && mode_i == rmms_pkg::MODE_TICK && nc_q != '0 |=> busy)
    else $error("tick item not started");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && finished_now_o |-> core_busy_o)
    else $error("finish on idle core");

  a_core_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({1'b0, core_number_o} < nc_q))
    else $error("result for inactive core");

endmodule
